[hw/rtl/spmc_pkg.sv]
// Shared types and constants for the skin pixel mean color unit.
// Holds the sequencer state type, register indexes and the fixed-point
// coefficients of the color conversion. No dependencies.
package spmc_pkg;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LUMA_R,
    ST_LUMA_G,
    ST_LUMA_B,
    ST_CR,
    ST_CB,
    ST_ROT_P,
    ST_ROT_U,
    ST_ROT_V,
    ST_SCALE_U,
    ST_SCALE_V,
    ST_DIST_U,
    ST_DIST_V,
    ST_FINISH,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  // Configuration register indexes
  localparam logic [1:0] REG_LUMA_SPLIT   = 2'd0;
  localparam logic [1:0] REG_LIMIT_DARK   = 2'd1;
  localparam logic [1:0] REG_LIMIT_BRIGHT = 2'd2;

  // Configuration reset values
  localparam logic [7:0]  LUMA_SPLIT_RST   = 8'd100;
  localparam logic [15:0] LIMIT_DARK_RST   = 16'd500;
  localparam logic [15:0] LIMIT_BRIGHT_RST = 16'd600;

  // Divider channel codes
  localparam logic [1:0] CH_BLUE  = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_RED   = 2'd2;

  // Accumulator widths
  localparam int SUM_W = 32;
  localparam int BIT_W = $clog2(SUM_W);

  // Luma and chroma coefficients, 14 fractional bits
  localparam logic signed [15:0] K_Y_R  = 16'sd4899;
  localparam logic signed [15:0] K_Y_G  = 16'sd9617;
  localparam logic signed [15:0] K_Y_B  = 16'sd1868;
  localparam logic signed [15:0] K_CR   = 16'sd11682;
  localparam logic signed [15:0] K_CB   = 16'sd9241;
  localparam logic signed [31:0] Y_ROUND = 32'sd8192;
  localparam logic signed [31:0] C_BIAS  = 32'sd2105344;

  // Ellipse center, rotation and scaling
  localparam logic signed [8:0]  CB_CENTER  = 9'sd109;
  localparam logic signed [8:0]  CR_CENTER  = 9'sd152;
  localparam logic signed [15:0] K_ROT_CR   = 16'sd819;
  localparam logic signed [15:0] K_ROT_CB   = 16'sd614;
  localparam logic signed [15:0] K_ROT_CB_N = -16'sd614;
  localparam logic signed [31:0] U_OFFSET   = 32'sd51;
  localparam logic signed [31:0] V_OFFSET   = 32'sd77;
  localparam logic signed [15:0] K_SCALE_U  = 16'sd41;
  localparam logic signed [15:0] K_SCALE_V  = 16'sd73;
  localparam int unsigned        ROT_SHIFT   = 5;
  localparam int unsigned        SCALE_SHIFT = 10;

endpackage

[hw/rtl/skin_pixel_mean_color_unit.sv]
// Skin pixel mean color unit: classifies masked BGR pixels in YCrCb space
// and reports the mean color and count of the skin pixels of each image.
// Depends on spmc_pkg.
//
// Usage:
//   Pixels enter on the in_ channel (valid/ready), one transaction per pixel,
//   in_last marking the final pixel of an image. A pixel with nonzero
//   in_mask_alpha is skipped. An examined pixel runs through one shared
//   16x16 multiply-add unit for 12 sequencer steps, and in_ready is low
//   meanwhile. After the last pixel the block divides each of the three
//   sums by the count with a restoring divider, one quotient bit per
//   cycle, and skips the division when no skin pixel was found. The result
//   then sits in an output register until the out_ transaction completes,
//   and the block already accepts pixels of the next image meanwhile; it
//   stalls only if a second result is ready before the first one was taken.
//   Configuration writes via cfg_we/cfg_index/cfg_data take effect at once
//   and must be made while the block is idle; the block itself does not
//   enforce this.
//   Reset (synchronous, active low) restores the register defaults, clears
//   all sums and the count, and drops out_valid.
module skin_pixel_mean_color_unit #(
  parameter int MAX_PIXELS_LOG2 = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [15:0]                cfg_data,
  // pixel input
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_blue,
  input  logic [7:0]                 in_green,
  input  logic [7:0]                 in_red,
  input  logic [7:0]                 in_mask_alpha,
  input  logic                       in_last,
  // result output
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_avg_blue,
  output logic [7:0]                 out_avg_green,
  output logic [7:0]                 out_avg_red,
  output logic [MAX_PIXELS_LOG2:0]   out_skin_count,
  output logic                       out_none_found
);

  localparam int CNT_W = MAX_PIXELS_LOG2 + 1;
  localparam int SUM_W = spmc_pkg::SUM_W;
  localparam int BIT_W = spmc_pkg::BIT_W;

  // Floor shift by 14 and clamp to 0..255
  function automatic logic [7:0] descale_clamp(input logic signed [31:0] x);
    logic signed [17:0] q;
    q = x[31:14];
    if (q < 18'sd0) begin
      return 8'd0;
    end else if (q > 18'sd255) begin
      return 8'd255;
    end
    return q[7:0];
  endfunction

  // Divide by a power of two, truncating toward zero
  function automatic logic signed [31:0] tdiv_pow2(input logic signed [31:0] x,
                                                   input int unsigned sh);
    logic signed [31:0] bias;
    bias = x[31] ? ((32'sd1 <<< sh) - 32'sd1) : 32'sd0;
    return (x + bias) >>> sh;
  endfunction

  // Configuration registers
  logic [7:0]  luma_split_r;
  logic [15:0] limit_dark_r;
  logic [15:0] limit_bright_r;

  // Sequencer
  spmc_pkg::state_t state_r, state_nxt;

  // Captured pixel
  logic [7:0] blue_r, green_r, red_r;
  logic       last_r;

  // Conversion datapath
  logic [7:0]         y_r;
  logic signed [8:0]  cr_r, cb_r;
  logic signed [19:0] pr_r;
  logic signed [15:0] u_r, v_r;
  logic signed [31:0] acc_r;

  // Shared multiply-add unit
  logic signed [15:0] mac_a, mac_b;
  logic signed [31:0] mac_add, mac_sum;

  // Accumulators
  logic [SUM_W-1:0] sum_blue_r, sum_green_r, sum_red_r;
  logic [CNT_W-1:0] count_r;

  // Divider
  logic [SUM_W-1:0] div_num_r;
  logic [CNT_W-1:0] rem_r;
  logic [7:0]       quo_r;
  logic [BIT_W-1:0] bit_r;
  logic [1:0]       ch_r;
  logic [7:0]       avg_b_r, avg_g_r, avg_r_r;
  logic [CNT_W:0]   div_trial, div_diff;
  logic             div_qbit;
  logic [CNT_W-1:0] div_rem;
  logic [7:0]       div_quo;
  logic             div_ch_done;
  logic [SUM_W-1:0] next_sum;

  // Output register
  logic             out_valid_r;
  logic [7:0]       out_b_r, out_g_r, out_r_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic             out_none_r;

  // Control
  logic             in_fire;
  logic             out_free;
  logic             skin;
  logic             emit_load;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign mac_sum  = mac_add + mac_a * mac_b;

  // Classify on the final step: squared radius against the luma-selected limit
  always_comb begin
    if (y_r < luma_split_r) begin
      skin = mac_sum < $signed({16'd0, limit_dark_r});
    end else begin
      skin = mac_sum < $signed({16'd0, limit_bright_r});
    end
  end

  // Restoring division step, one quotient bit per cycle
  always_comb begin
    div_trial   = {rem_r, div_num_r[SUM_W-1]};
    div_diff    = div_trial - {1'b0, count_r};
    div_qbit    = !div_diff[CNT_W];
    div_rem     = div_qbit ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
    div_quo     = {quo_r[6:0], div_qbit};
    div_ch_done = (bit_r == BIT_W'(SUM_W - 1));
    case (ch_r)
      spmc_pkg::CH_BLUE:  next_sum = sum_green_r;
      spmc_pkg::CH_GREEN: next_sum = sum_red_r;
      default:            next_sum = sum_blue_r;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spmc_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_mask_alpha == 8'd0) begin
            state_nxt = spmc_pkg::ST_LUMA_R;
          end else if (in_last) begin
            state_nxt = spmc_pkg::ST_FINISH;
          end
        end
      end
      spmc_pkg::ST_LUMA_R:  state_nxt = spmc_pkg::ST_LUMA_G;
      spmc_pkg::ST_LUMA_G:  state_nxt = spmc_pkg::ST_LUMA_B;
      spmc_pkg::ST_LUMA_B:  state_nxt = spmc_pkg::ST_CR;
      spmc_pkg::ST_CR:      state_nxt = spmc_pkg::ST_CB;
      spmc_pkg::ST_CB:      state_nxt = spmc_pkg::ST_ROT_P;
      spmc_pkg::ST_ROT_P:   state_nxt = spmc_pkg::ST_ROT_U;
      spmc_pkg::ST_ROT_U:   state_nxt = spmc_pkg::ST_ROT_V;
      spmc_pkg::ST_ROT_V:   state_nxt = spmc_pkg::ST_SCALE_U;
      spmc_pkg::ST_SCALE_U: state_nxt = spmc_pkg::ST_SCALE_V;
      spmc_pkg::ST_SCALE_V: state_nxt = spmc_pkg::ST_DIST_U;
      spmc_pkg::ST_DIST_U:  state_nxt = spmc_pkg::ST_DIST_V;
      spmc_pkg::ST_DIST_V: begin
        state_nxt = last_r ? spmc_pkg::ST_FINISH : spmc_pkg::ST_IDLE;
      end
      spmc_pkg::ST_FINISH: begin
        state_nxt = (count_r == '0) ? spmc_pkg::ST_EMIT : spmc_pkg::ST_DIVIDE;
      end
      spmc_pkg::ST_DIVIDE: begin
        if (div_ch_done && ch_r == spmc_pkg::CH_RED) begin
          state_nxt = spmc_pkg::ST_EMIT;
        end
      end
      spmc_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = spmc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = spmc_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and multiply-add operands
  always_comb begin
    in_ready  = 1'b0;
    emit_load = 1'b0;
    mac_a     = 16'sd0;
    mac_b     = 16'sd0;
    mac_add   = 32'sd0;
    case (state_r)
      spmc_pkg::ST_IDLE: in_ready = 1'b1;
      spmc_pkg::ST_LUMA_R: begin
        mac_a   = $signed({8'd0, red_r});
        mac_b   = spmc_pkg::K_Y_R;
        mac_add = spmc_pkg::Y_ROUND;
      end
      spmc_pkg::ST_LUMA_G: begin
        mac_a   = $signed({8'd0, green_r});
        mac_b   = spmc_pkg::K_Y_G;
        mac_add = acc_r;
      end
      spmc_pkg::ST_LUMA_B: begin
        mac_a   = $signed({8'd0, blue_r});
        mac_b   = spmc_pkg::K_Y_B;
        mac_add = acc_r;
      end
      spmc_pkg::ST_CR: begin
        mac_a   = $signed({8'd0, red_r}) - $signed({8'd0, y_r});
        mac_b   = spmc_pkg::K_CR;
        mac_add = spmc_pkg::C_BIAS;
      end
      spmc_pkg::ST_CB: begin
        mac_a   = $signed({8'd0, blue_r}) - $signed({8'd0, y_r});
        mac_b   = spmc_pkg::K_CB;
        mac_add = spmc_pkg::C_BIAS;
      end
      spmc_pkg::ST_ROT_P: begin
        mac_a = {{7{cr_r[8]}}, cr_r};
        mac_b = spmc_pkg::K_ROT_CR;
      end
      spmc_pkg::ST_ROT_U: begin
        mac_a   = {{7{cb_r[8]}}, cb_r};
        mac_b   = spmc_pkg::K_ROT_CB_N;
        mac_add = {{12{pr_r[19]}}, pr_r};
      end
      spmc_pkg::ST_ROT_V: begin
        mac_a   = {{7{cb_r[8]}}, cb_r};
        mac_b   = spmc_pkg::K_ROT_CB;
        mac_add = {{12{pr_r[19]}}, pr_r};
      end
      spmc_pkg::ST_SCALE_U: begin
        mac_a = u_r;
        mac_b = spmc_pkg::K_SCALE_U;
      end
      spmc_pkg::ST_SCALE_V: begin
        mac_a = v_r;
        mac_b = spmc_pkg::K_SCALE_V;
      end
      spmc_pkg::ST_DIST_U: begin
        mac_a = u_r;
        mac_b = u_r;
      end
      spmc_pkg::ST_DIST_V: begin
        mac_a   = v_r;
        mac_b   = v_r;
        mac_add = acc_r;
      end
      spmc_pkg::ST_EMIT: emit_load = out_free;
      default: ;
    endcase
  end

  // Control registers: state, configuration, accumulators, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= spmc_pkg::ST_IDLE;
      luma_split_r   <= spmc_pkg::LUMA_SPLIT_RST;
      limit_dark_r   <= spmc_pkg::LIMIT_DARK_RST;
      limit_bright_r <= spmc_pkg::LIMIT_BRIGHT_RST;
      sum_blue_r     <= '0;
      sum_green_r    <= '0;
      sum_red_r      <= '0;
      count_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Write configuration; an unused index is dropped
      if (cfg_we) begin
        case (cfg_index)
          spmc_pkg::REG_LUMA_SPLIT:   luma_split_r   <= cfg_data[7:0];
          spmc_pkg::REG_LIMIT_DARK:   limit_dark_r   <= cfg_data;
          spmc_pkg::REG_LIMIT_BRIGHT: limit_bright_r <= cfg_data;
          default: ;
        endcase
      end

      // Accumulate a skin pixel until the count saturates; clear on emit
      if (emit_load) begin
        sum_blue_r  <= '0;
        sum_green_r <= '0;
        sum_red_r   <= '0;
        count_r     <= '0;
      end else if (state_r == spmc_pkg::ST_DIST_V && skin && !count_r[CNT_W-1]) begin
        sum_blue_r  <= sum_blue_r + SUM_W'(blue_r);
        sum_green_r <= sum_green_r + SUM_W'(green_r);
        sum_red_r   <= sum_red_r + SUM_W'(red_r);
        count_r     <= count_r + CNT_W'(1);
      end

      // Hold the result until the output transaction completes
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      blue_r  <= in_blue;
      green_r <= in_green;
      red_r   <= in_red;
      last_r  <= in_last;
    end

    case (state_r)
      spmc_pkg::ST_LUMA_R, spmc_pkg::ST_LUMA_G, spmc_pkg::ST_DIST_U: acc_r <= mac_sum;
      spmc_pkg::ST_LUMA_B: y_r  <= mac_sum[21:14];
      spmc_pkg::ST_CR:     cr_r <= $signed({1'b0, descale_clamp(mac_sum)}) - spmc_pkg::CR_CENTER;
      spmc_pkg::ST_CB:     cb_r <= $signed({1'b0, descale_clamp(mac_sum)}) - spmc_pkg::CB_CENTER;
      spmc_pkg::ST_ROT_P:  pr_r <= mac_sum[19:0];
      spmc_pkg::ST_ROT_U: begin
        u_r <= 16'(tdiv_pow2(mac_sum, spmc_pkg::ROT_SHIFT) + spmc_pkg::U_OFFSET);
      end
      spmc_pkg::ST_ROT_V: begin
        v_r <= 16'(tdiv_pow2(mac_sum, spmc_pkg::ROT_SHIFT) + spmc_pkg::V_OFFSET);
      end
      spmc_pkg::ST_SCALE_U: u_r <= 16'(tdiv_pow2(mac_sum, spmc_pkg::SCALE_SHIFT));
      spmc_pkg::ST_SCALE_V: v_r <= 16'(tdiv_pow2(mac_sum, spmc_pkg::SCALE_SHIFT));
      default: ;
    endcase

    // Start the divider on blue and zero the averages; they stay zero when nothing matched
    if (state_r == spmc_pkg::ST_FINISH) begin
      div_num_r <= sum_blue_r;
      rem_r     <= '0;
      quo_r     <= '0;
      bit_r     <= '0;
      ch_r      <= spmc_pkg::CH_BLUE;
      avg_b_r   <= '0;
      avg_g_r   <= '0;
      avg_r_r   <= '0;
    end else if (state_r == spmc_pkg::ST_DIVIDE) begin
      if (div_ch_done) begin
        case (ch_r)
          spmc_pkg::CH_BLUE:  avg_b_r <= div_quo;
          spmc_pkg::CH_GREEN: avg_g_r <= div_quo;
          default:            avg_r_r <= div_quo;
        endcase
        div_num_r <= next_sum;
        rem_r     <= '0;
        quo_r     <= '0;
        bit_r     <= '0;
        ch_r      <= ch_r + 2'd1;
      end else begin
        div_num_r <= {div_num_r[SUM_W-2:0], 1'b0};
        rem_r     <= div_rem;
        quo_r     <= div_quo;
        bit_r     <= bit_r + BIT_W'(1);
      end
    end

    // Load the output register
    if (emit_load) begin
      out_b_r    <= avg_b_r;
      out_g_r    <= avg_g_r;
      out_r_r    <= avg_r_r;
      out_cnt_r  <= count_r;
      out_none_r <= (count_r == '0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_avg_blue   = out_b_r;
  assign out_avg_green  = out_g_r;
  assign out_avg_red    = out_r_r;
  assign out_skin_count = out_cnt_r;
  assign out_none_found = out_none_r;

  // A result appears only after the emit step
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == spmc_pkg::ST_EMIT))
    else $error("result raised outside emit step");

  // The divider never runs with a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == spmc_pkg::ST_DIVIDE |-> count_r != '0)
    else $error("divide started with zero count");

  // The count saturates at its limit
  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    count_r[CNT_W-1] |-> count_r[CNT_W-2:0] == '0)
    else $error("skin count beyond limit");

  // An empty image reports zero averages and count
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_none_r |->
      out_cnt_r == '0 && out_b_r == 8'd0 && out_g_r == 8'd0 && out_r_r == 8'd0)
    else $error("empty result carries data");

  // The flag matches the count
  a_none_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_none_r |-> out_cnt_r != '0)
    else $error("nonempty result with zero count");

endmodule
